FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the strip classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types and fixed constants of the polar strip classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Register map of the configuration port
    typedef enum logic [1:0] {
        REG_CENTER_X     = 2'd0,
        REG_CENTER_Z     = 2'd1,
        REG_FIRST_RADIUS = 2'd2,
        REG_BAND_WIDTH   = 2'd3
    } psc_reg_t;

    localparam int BW_W        = 16;   // band width register
    localparam int NUM_EDGES   = 17;   // strip edges 0..16
    localparam int EDGE_IDX_W  = 5;    // index over the edges
    localparam int KBW_W       = BW_W + EDGE_IDX_W;
    localparam int FULL_BANDS  = 13;   // bands under the widest angle limit
    localparam int STRIP_W     = 4;
    localparam int NUM_LIMITS  = 4;
    localparam int TAN_W       = 16;   // Q0.16

    // tan of 20, 17.555, 14.03 and 9.14 degrees, Q0.16 rounded
    localparam logic [TAN_W-1:0] TAN_Q16 [NUM_LIMITS] = '{
        16'd23853, 16'd20733, 16'd16376, 16'd10544
    };

    typedef struct packed {
        logic                  in_range;
        logic [NUM_LIMITS-1:0] ang_ok;
    } psc_flags_t;

endpackage

FILE: hw/rtl/polar_strip_classifier_unit.sv
// ----------------------------------------------------------------------------
// polar_strip_classifier_unit
// Classifies a local hit position onto one of 16 arc strips of a sensor.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | sink      | in_valid / in_stall  | pos_x, pos_z
//  out     | source    | out_valid / out_stall| is_hit, strip_index
//  cfg     | sink      | cfg_wen              | cfg_index, cfg_wdata
//
//  One beat per cycle sustained, while neither out_stall nor a table rebuild
//  holds the flow, through six register stages (two offset/magnitude stages,
//  squares, sum, edge compare, strip select); out_valid and the result come
//  from the strip select stage.
//  After reset and after every write of first_radius or band_width the edge
//  table is rebuilt through one shared squarer: in_stall stays high until the
//  last square is stored. Center writes take effect at once.
//  out_stall holds the result stage; a stage advances whenever the stage after
//  it is empty or moving, so bubbles close up and the input side keeps moving
//  until all six stages hold a beat.
//
`include "assert_macros.svh"

module polar_strip_classifier_unit #(
    parameter int COORD_BITS = 20,
    localparam int CFG_DW = (COORD_BITS > psc_pkg::BW_W) ? COORD_BITS : psc_pkg::BW_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wen,
    input  psc_pkg::psc_reg_t             cfg_index,
    input  logic [CFG_DW-1:0]             cfg_wdata,
    // input beats
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  pos_x,
    input  logic signed [COORD_BITS-1:0]  pos_z,
    // result beats
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_hit,
    output logic [psc_pkg::STRIP_W-1:0]   strip_index
);
    import psc_pkg::*;

    localparam int EW = ((COORD_BITS - 1 > KBW_W) ? COORD_BITS - 1 : KBW_W) + 1;
    localparam int AW = COORD_BITS + 1;
    localparam int SW = 2 * AW + 1;

    // configuration registers
    logic signed [COORD_BITS-1:0] center_x_reg, center_z_reg;
    logic [COORD_BITS-2:0]        first_radius_reg;
    logic [BW_W-1:0]              band_width_reg;

    logic wr_cx, wr_cz, wr_fr, wr_bw;
    logic table_start, table_busy;

    logic [NUM_EDGES-1:0][2*EW-1:0] edge_sq;
    logic [EW-1:0]                  outer;

    logic        geom_in_valid, geom_in_ready;
    logic        geom_out_valid, band_in_ready;
    logic [SW-1:0] r2;
    psc_flags_t  flags;

    // decode the register index
    always_comb
    begin
        wr_cx = 1'b0;
        wr_cz = 1'b0;
        wr_fr = 1'b0;
        wr_bw = 1'b0;
        unique case (cfg_index)
            REG_CENTER_X:     wr_cx = cfg_wen;
            REG_CENTER_Z:     wr_cz = cfg_wen;
            REG_FIRST_RADIUS: wr_fr = cfg_wen;
            REG_BAND_WIDTH:   wr_bw = cfg_wen;
            default:          wr_cx = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_z_reg     <= '0;
            first_radius_reg <= '0;
            band_width_reg   <= BW_W'(1);
        end
        else
        begin
            if (wr_cx) center_x_reg     <= cfg_wdata[COORD_BITS-1:0];
            if (wr_cz) center_z_reg     <= cfg_wdata[COORD_BITS-1:0];
            if (wr_fr) first_radius_reg <= cfg_wdata[COORD_BITS-2:0];
            if (wr_bw) band_width_reg   <= cfg_wdata[BW_W-1:0];
        end
    end

    // a radius or width write invalidates the whole edge table
    assign table_start = wr_fr || wr_bw;

    psc_edge_table #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (table_start),
        .first_radius (first_radius_reg),
        .band_width   (band_width_reg),
        .edge_sq      (edge_sq),
        .outer        (outer),
        .busy         (table_busy)
    );

    // hold the input while the table is stale
    assign geom_in_valid = in_valid && !table_busy && !table_start;
    assign in_stall      = table_busy || table_start || !geom_in_ready;

    psc_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_in_valid),
        .in_ready  (geom_in_ready),
        .pos_x     (pos_x),
        .pos_z     (pos_z),
        .center_x  (center_x_reg),
        .center_z  (center_z_reg),
        .outer     (outer),
        .out_valid (geom_out_valid),
        .out_ready (band_in_ready),
        .r2        (r2),
        .flags     (flags)
    );

    psc_band #(
        .COORD_BITS (COORD_BITS)
    ) u_band (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (geom_out_valid),
        .in_ready    (band_in_ready),
        .r2          (r2),
        .flags       (flags),
        .edge_sq     (edge_sq),
        .out_valid   (out_valid),
        .out_ready   (!out_stall),
        .is_hit      (is_hit),
        .strip_index (strip_index)
    );

    `ASSERT_IMPLIES(a_no_accept_stale, clk, rst_n, in_valid && !in_stall, !table_busy,
        "input beat taken while edge table rebuilds")

endmodule

FILE: hw/rtl/psc_edge_table.sv
// ----------------------------------------------------------------------------
// psc_edge_table
// Rebuilds the squared strip edges after reset or a radius/width write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_edge_table #(
    parameter int COORD_BITS = 20,
    localparam int EW = ((COORD_BITS - 1 > psc_pkg::KBW_W) ? COORD_BITS - 1
                                                            : psc_pkg::KBW_W) + 1
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [COORD_BITS-2:0]                      first_radius,
    input  logic [psc_pkg::BW_W-1:0]                   band_width,
    output logic [psc_pkg::NUM_EDGES-1:0][2*EW-1:0]    edge_sq,
    output logic [EW-1:0]                              outer,
    output logic                                       busy
);
    import psc_pkg::*;

    localparam logic [EDGE_IDX_W-1:0] LAST_EDGE = EDGE_IDX_W'(NUM_EDGES - 1);

    logic                  active_reg;
    logic [EDGE_IDX_W-1:0] k_reg;
    logic                  e_vld_reg;
    logic [EDGE_IDX_W-1:0] e_idx_reg;
    logic [EW-1:0]         e_reg;
    logic [EW-1:0]         e_next;
    logic [KBW_W-1:0]      kbw;
    logic [NUM_EDGES-1:0][2*EW-1:0] sq_reg;
    logic [EW-1:0]         outer_reg;

    assign kbw    = KBW_W'(k_reg) * KBW_W'(band_width);
    assign e_next = EW'(first_radius) + EW'(kbw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
            e_vld_reg  <= 1'b0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
            e_vld_reg  <= 1'b0;
        end
        else if (active_reg)
        begin
            e_vld_reg <= 1'b1;
            if (k_reg == LAST_EDGE)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
        else
        begin
            e_vld_reg <= 1'b0;
        end
    end

    // edge value and its square, one stage apart
    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            e_reg     <= e_next;
            e_idx_reg <= k_reg;
        end
        if (e_vld_reg)
        begin
            sq_reg[e_idx_reg] <= (2*EW)'(e_reg * e_reg);
            if (e_idx_reg == LAST_EDGE)
            begin
                outer_reg <= e_reg;
            end
        end
    end

    assign edge_sq = sq_reg;
    assign outer   = outer_reg;
    assign busy    = active_reg || e_vld_reg;

    `ASSERT_NEXT(a_sweep_end, clk, rst_n,
        active_reg && !start && k_reg == LAST_EDGE,
        !active_reg && e_vld_reg && e_idx_reg == LAST_EDGE,
        "edge sweep did not close on the last edge")

endmodule

FILE: hw/rtl/psc_geom.sv
// ----------------------------------------------------------------------------
// psc_geom
// Offset, magnitude, squares, sum, range and angle tests: four pipeline stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_geom #(
    parameter int COORD_BITS = 20,
    localparam int EW = ((COORD_BITS - 1 > psc_pkg::KBW_W) ? COORD_BITS - 1
                                                            : psc_pkg::KBW_W) + 1,
    localparam int AW = COORD_BITS + 1,
    localparam int SW = 2 * AW + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  pos_x,
    input  logic signed [COORD_BITS-1:0]  pos_z,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_z,
    input  logic [EW-1:0]                 outer,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SW-1:0]                 r2,
    output psc_pkg::psc_flags_t           flags
);
    import psc_pkg::*;

    localparam int MW = (AW > EW) ? AW : EW;
    localparam int PW = AW + TAN_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic signed [COORD_BITS:0] dx_next, dz_next, dx1_reg, dz1_reg;
    // stage 2
    logic [AW-1:0] adx_next, udz_next, adx2_reg, udz2_reg;
    logic          rng_next, rng2_reg;
    // stage 3
    logic [2*AW-1:0] ax2_reg, az2_reg;
    logic [PW-1:0]   prod_reg [NUM_LIMITS];
    logic [AW-1:0]   adx3_reg;
    logic            rng3_reg;
    // stage 4
    logic [SW-1:0]   r2_reg;
    psc_flags_t      flags_reg;
    logic [NUM_LIMITS-1:0] ang_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign dx_next = $signed({pos_x[COORD_BITS-1], pos_x})
                   - $signed({center_x[COORD_BITS-1], center_x});
    assign dz_next = $signed({pos_z[COORD_BITS-1], pos_z})
                   - $signed({center_z[COORD_BITS-1], center_z});

    // a negated minimum wraps to 2^COORD_BITS, which is its magnitude
    assign adx_next = dx1_reg[COORD_BITS] ? AW'(-dx1_reg) : AW'(dx1_reg);
    assign udz_next = AW'(dz1_reg);
    assign rng_next = !dz1_reg[COORD_BITS] && (dz1_reg != '0)
                   && (MW'(adx_next) < MW'(outer))
                   && (MW'(udz_next) < MW'(outer));

    always_comb
    begin
        for (int j = 0; j < NUM_LIMITS; j++)
        begin
            ang_next[j] = {adx3_reg, {TAN_W{1'b0}}} < prod_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx1_reg <= dx_next;
            dz1_reg <= dz_next;
        end
        if (rdy2)
        begin
            adx2_reg <= adx_next;
            udz2_reg <= udz_next;
            rng2_reg <= rng_next;
        end
        if (rdy3)
        begin
            ax2_reg  <= (2*AW)'(adx2_reg) * (2*AW)'(adx2_reg);
            az2_reg  <= (2*AW)'(udz2_reg) * (2*AW)'(udz2_reg);
            for (int j = 0; j < NUM_LIMITS; j++)
            begin
                prod_reg[j] <= PW'(udz2_reg) * PW'(TAN_Q16[j]);
            end
            adx3_reg <= adx2_reg;
            rng3_reg <= rng2_reg;
        end
        if (rdy4)
        begin
            r2_reg             <= SW'(ax2_reg) + SW'(az2_reg);
            flags_reg.in_range <= rng3_reg;
            flags_reg.ang_ok   <= ang_next;
        end
    end

    assign out_valid = v4_reg;
    assign r2        = r2_reg;
    assign flags     = flags_reg;

    `ASSERT_NEXT(a_beat_advance, clk, rst_n, v1_reg && rdy2, v2_reg,
        "beat lost between first and second stage")

endmodule

FILE: hw/rtl/psc_band.sv
// ----------------------------------------------------------------------------
// psc_band
// Compares the squared radius with the edge table and picks the strip.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_band #(
    parameter int COORD_BITS = 20,
    localparam int EW = ((COORD_BITS - 1 > psc_pkg::KBW_W) ? COORD_BITS - 1
                                                            : psc_pkg::KBW_W) + 1,
    localparam int AW = COORD_BITS + 1,
    localparam int SW = 2 * AW + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [SW-1:0]                           r2,
    input  psc_pkg::psc_flags_t                     flags,
    input  logic [psc_pkg::NUM_EDGES-1:0][2*EW-1:0] edge_sq,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    is_hit,
    output logic [psc_pkg::STRIP_W-1:0]             strip_index
);
    import psc_pkg::*;

    localparam int CW = (SW > 2 * EW) ? SW : 2 * EW;

    logic v5_reg, v6_reg;
    logic rdy5, rdy6;

    logic [NUM_EDGES-1:1] lt_next, lt5_reg;
    logic                 gt0_next, gt05_reg;
    psc_flags_t           flags5_reg;

    logic                 hit_next, hit_reg;
    logic [STRIP_W-1:0]   strip_next, strip_enc, strip_reg;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        gt0_next = CW'(r2) > CW'(edge_sq[0]);
        for (int k = 1; k < NUM_EDGES; k++)
        begin
            lt_next[k] = CW'(r2) < CW'(edge_sq[k]);
        end
    end

    // lowest full band whose outer edge lies beyond the radius
    always_comb
    begin
        strip_enc = STRIP_W'(FULL_BANDS - 1);
        for (int k = FULL_BANDS - 2; k >= 0; k--)
        begin
            if (lt5_reg[k + 1])
            begin
                strip_enc = STRIP_W'(k);
            end
        end
    end

    always_comb
    begin
        hit_next   = 1'b0;
        strip_next = '0;
        if (flags5_reg.in_range && gt05_reg)
        begin
            if (lt5_reg[FULL_BANDS] && flags5_reg.ang_ok[0])
            begin
                hit_next   = 1'b1;
                strip_next = strip_enc;
            end
            else if (lt5_reg[FULL_BANDS + 1] && flags5_reg.ang_ok[1])
            begin
                hit_next   = 1'b1;
                strip_next = STRIP_W'(FULL_BANDS);
            end
            else if (lt5_reg[FULL_BANDS + 2] && flags5_reg.ang_ok[2])
            begin
                hit_next   = 1'b1;
                strip_next = STRIP_W'(FULL_BANDS + 1);
            end
            else if (lt5_reg[FULL_BANDS + 3] && flags5_reg.ang_ok[3])
            begin
                hit_next   = 1'b1;
                strip_next = STRIP_W'(FULL_BANDS + 2);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            lt5_reg    <= lt_next;
            gt05_reg   <= gt0_next;
            flags5_reg <= flags;
        end
        if (rdy6)
        begin
            hit_reg   <= hit_next;
            strip_reg <= strip_next;
        end
    end

    assign out_valid   = v6_reg;
    assign is_hit      = hit_reg;
    assign strip_index = strip_reg;

    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, v6_reg && !hit_reg, strip_reg == '0,
        "miss reported with a nonzero strip")

endmodule
